[rtl/wcma_pkg.sv]
// Shared constants, request and register codes, and pipeline tag types
// for the weighted coupling-matrix accumulator. No dependencies.
`default_nettype none

package wcma_pkg;

    // Default matrix capacity
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // Field widths
    localparam int REQ_W     = 3;
    localparam int IDX_W     = 5;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 64;
    localparam int SIZE_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_A = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

    // Configuration reset values
    localparam logic [SIZE_W-1:0] ROWS_RESET  = 6'd8;
    localparam logic [SIZE_W-1:0] COLS_RESET  = 6'd8;
    localparam logic [VAL_W-1:0]  SCALE_RESET = 32'h0001_0000;

    // Q32.32 saturation limits
    localparam logic [ACC_W-1:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 64'h8000_0000_0000_0000;

    // Tag that travels with each matrix entry down the product pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } mac_tag_t;

    // Status of a finished product term
    typedef struct packed {
        logic valid;
        logic last;
        logic sat;
    } mac_res_t;

endpackage

`default_nettype wire

[rtl/wcma_mac.sv]
// Six-stage product pipeline: (scale*weight) * (a*b) in Q32.32 with
// rounding and saturation. Depends on wcma_pkg.
`default_nettype none

module wcma_mac
    import wcma_pkg::*;
#(
    parameter int AW = 10
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mac_tag_t                in_tag,
    input  wire logic [AW-1:0]           in_addr,
    input  wire logic signed [VAL_W-1:0] row_val,
    input  wire logic signed [VAL_W-1:0] col_val,
    input  wire logic [ACC_W-1:0]        sw_mag,
    input  wire logic                    sw_neg,
    output mac_res_t                     out_res,
    output logic [AW-1:0]                out_addr,
    output logic [ACC_W-1:0]             term
);

    localparam int STAGES = 6;

    mac_tag_t      tag_pipe_reg  [STAGES];
    logic [AW-1:0] addr_pipe_reg [STAGES];

    logic signed [ACC_W-1:0] ab_next;
    logic signed [ACC_W-1:0] ab_reg;
    logic [ACC_W-1:0]        v_next;
    logic [ACC_W-1:0]        v_reg;
    logic                    neg_s3_reg;
    logic                    neg_s4_reg;
    logic                    neg_s5_reg;
    logic                    neg_s6_reg;
    logic [ACC_W-1:0]        ll_next;
    logic [ACC_W-1:0]        lh_next;
    logic [ACC_W-1:0]        hl_next;
    logic [ACC_W-1:0]        hh_next;
    logic [ACC_W-1:0]        ll_reg;
    logic [ACC_W-1:0]        lh_reg;
    logic [ACC_W-1:0]        hl_reg;
    logic [ACC_W-1:0]        hh_reg;
    logic [ACC_W-1:0]        hh_s5_reg;
    logic [ACC_W+1:0]        s_next;
    logic [ACC_W+1:0]        s_reg;
    logic [95:0]             r_next;
    logic [95:0]             r_reg;
    logic [ACC_W-1:0]        term_next;
    logic                    sat_next;
    logic [ACC_W-1:0]        term_reg;
    logic                    sat_reg;
    logic [ACC_W-1:0]        mag;
    logic                    over;

    // Tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                tag_pipe_reg[k] <= '0;
            end
        end
        else
        begin
            tag_pipe_reg[0] <= in_tag;
            for (int k = 1; k < STAGES; k++)
            begin
                tag_pipe_reg[k] <= tag_pipe_reg[k-1];
            end
        end
    end

    // Arithmetic
    always_comb
    begin
        ab_next = row_val * col_val;
        v_next  = ab_reg[ACC_W-1] ? ACC_W'(-ab_reg) : ACC_W'(ab_reg);
        ll_next = sw_mag[31:0]  * v_reg[31:0];
        lh_next = sw_mag[31:0]  * v_reg[63:32];
        hl_next = sw_mag[63:32] * v_reg[31:0];
        hh_next = sw_mag[63:32] * v_reg[63:32];
        // cross terms plus rounding bit, all at weight 2^32
        s_next  = (ACC_W+2)'(lh_reg) + (ACC_W+2)'(hl_reg)
                + (ACC_W+2)'(ll_reg[63:32]) + (ACC_W+2)'(ll_reg[31]);
        r_next  = {hh_s5_reg, 32'd0} + 96'(s_reg);
    end

    // Reduce the rounded magnitude to a signed Q32.32 term
    always_comb
    begin
        mag       = r_reg[63:0];
        over      = |r_reg[95:64];
        sat_next  = 1'b0;
        term_next = mag;
        if (over)
        begin
            sat_next  = 1'b1;
            term_next = neg_s6_reg ? ACC_MIN : ACC_MAX;
        end
        else if (neg_s6_reg)
        begin
            if (mag > ACC_MIN)
            begin
                sat_next  = 1'b1;
                term_next = ACC_MIN;
            end
            else
            begin
                term_next = ~mag + 64'd1;
            end
        end
        else if (mag[63])
        begin
            sat_next  = 1'b1;
            term_next = ACC_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_pipe_reg[0] <= in_addr;
        for (int k = 1; k < STAGES; k++)
        begin
            addr_pipe_reg[k] <= addr_pipe_reg[k-1];
        end
        ab_reg     <= ab_next;
        v_reg      <= v_next;
        neg_s3_reg <= sw_neg ^ ab_reg[ACC_W-1];
        ll_reg     <= ll_next;
        lh_reg     <= lh_next;
        hl_reg     <= hl_next;
        hh_reg     <= hh_next;
        neg_s4_reg <= neg_s3_reg;
        s_reg      <= s_next;
        hh_s5_reg  <= hh_reg;
        neg_s5_reg <= neg_s4_reg;
        r_reg      <= r_next;
        neg_s6_reg <= neg_s5_reg;
        term_reg   <= term_next;
        sat_reg    <= sat_next;
    end

    assign out_res.valid = tag_pipe_reg[STAGES-1].valid;
    assign out_res.last  = tag_pipe_reg[STAGES-1].last;
    assign out_res.sat   = sat_reg;
    assign out_addr      = addr_pipe_reg[STAGES-1];
    assign term          = term_reg;

endmodule

`default_nettype wire

[rtl/weighted_coupling_matrix_accumulate.sv]
// Top level of the weighted coupling-matrix accumulator: control sequencer,
// shape-value memory and accumulator memory. Depends on wcma_pkg, wcma_mac.
`default_nettype none

// Usage
//   Command channel: drive req_type, row_index, col_index and value with
//   start high; the beat is taken at the rising edge where busy is low.
//   Each command gives exactly one result beat: done is high for one cycle
//   with read_value, status and saturated. The receiver cannot stall it.
//   Configuration: cfg_write with cfg_index/cfg_data writes rows_in_use,
//   cols_in_use or scale at once; write only while the block is idle.
// Sequence of states from the accepting edge to the done cycle
//   load A / load B / unknown request : done is set from the idle state
//   read                              : READ, then done; out of range, as a load
//   clear                             : CLEAR over all MAX_ROWS*MAX_COLS entries
//   update                            : PREP, ISSUE, DRAIN, or PREP if a size is 0
//   An update streams one matrix entry per cycle through the single
//   product pipeline and the read-modify-write port of the accumulator
//   memory; DRAIN holds until the last entry has been written back.
//   One command at a time: busy drops as its result beat goes out; loads keep it low.
// Reset
//   Reset sets the registers to 8, 8 and 1.0, then a clearing pass zeroes
//   the accumulator memory one entry per cycle, all MAX_ROWS*MAX_COLS entries
//   (1024 by default), with busy high and no result beat.
module weighted_coupling_matrix_accumulate
    import wcma_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [REQ_W-1:0]        req_type,
    input  wire logic [IDX_W-1:0]        row_index,
    input  wire logic [IDX_W-1:0]        col_index,
    input  wire logic signed [VAL_W-1:0] value,
    output logic                         done,
    output logic signed [ACC_W-1:0]      read_value,
    output logic                         status,
    output logic                         saturated,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SDEPTH  = MAX_ROWS + MAX_COLS;
    localparam int SW      = $clog2(SDEPTH);
    localparam int ROW_CAP = (MAX_ROWS < 63) ? MAX_ROWS : 63;
    localparam int COL_CAP = (MAX_COLS < 63) ? MAX_COLS : 63;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_ISSUE = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    // Configuration
    logic [SIZE_W-1:0]       rows_in_use_reg;
    logic [SIZE_W-1:0]       cols_in_use_reg;
    logic signed [VAL_W-1:0] scale_reg;
    logic [SIZE_W-1:0]       eff_rows;
    logic [SIZE_W-1:0]       eff_cols;

    // Sequencer
    logic [2:0]              state_reg, state_next;
    logic [SIZE_W-1:0]       i_reg, i_next;
    logic [SIZE_W-1:0]       j_reg, j_next;
    logic [AW-1:0]           base_reg, base_next;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic                    clr_reply_reg, clr_reply_next;
    logic                    sat_flag_reg, sat_flag_next;
    logic                    done_reg, done_next;
    logic                    status_reg, status_next;
    logic [ACC_W-1:0]        read_value_reg, read_value_next;
    logic signed [ACC_W-1:0] sw_reg, sw_next;
    logic [ACC_W-1:0]        sw_mag_reg, sw_mag_next;
    logic                    sw_neg_reg, sw_neg_next;
    mac_tag_t                p1_tag_reg, p1_tag_next;
    logic [AW-1:0]           p1_addr_reg, p1_addr_next;
    logic                    row_ok;
    logic                    col_ok;
    logic                    last_entry;
    logic                    col_wrap;

    // Shape-value memory: system A values at 0.., system B after MAX_ROWS
    logic [VAL_W-1:0]        shape_mem [SDEPTH];
    logic                    shape_we;
    logic [SW-1:0]           shape_wa;
    logic [SW-1:0]           shape_ra_row;
    logic [SW-1:0]           shape_ra_col;
    logic signed [VAL_W-1:0] row_q_reg;
    logic signed [VAL_W-1:0] col_q_reg;

    // Accumulator memory
    logic [ACC_W-1:0]        acc_mem [DEPTH];
    logic                    acc_clr_we;
    logic                    acc_we;
    logic [AW-1:0]           acc_wa;
    logic [ACC_W-1:0]        acc_wd;
    logic [AW-1:0]           acc_ra;
    logic [AW-1:0]           req_addr;
    logic [ACC_W-1:0]        acc_q_reg;

    // Product pipeline and write-back stage
    mac_res_t                mac_res;
    logic [AW-1:0]           mac_addr;
    logic [ACC_W-1:0]        mac_term;
    mac_res_t                p8_res_reg;
    logic [AW-1:0]           p8_addr_reg;
    logic [ACC_W-1:0]        term_q_reg;
    logic [ACC_W-1:0]        sum;
    logic                    add_ovf;
    logic [ACC_W-1:0]        add_result;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= ROWS_RESET;
            cols_in_use_reg <= COLS_RESET;
            scale_reg       <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROWS:  rows_in_use_reg <= cfg_data[SIZE_W-1:0];
                CFG_COLS:  cols_in_use_reg <= cfg_data[SIZE_W-1:0];
                CFG_SCALE: scale_reg       <= cfg_data;
                default:   ; // drop writes beyond the register list
            endcase
        end
    end

    // Clamp the sizes in use to the capacity of the store
    assign eff_rows = (rows_in_use_reg > SIZE_W'(ROW_CAP)) ? SIZE_W'(ROW_CAP) : rows_in_use_reg;
    assign eff_cols = (cols_in_use_reg > SIZE_W'(COL_CAP)) ? SIZE_W'(COL_CAP) : cols_in_use_reg;

    assign row_ok     = SIZE_W'(row_index) < eff_rows;
    assign col_ok     = SIZE_W'(col_index) < eff_cols;
    assign col_wrap   = (j_reg == eff_cols - 6'd1);
    assign last_entry = (i_reg == eff_rows - 6'd1) && col_wrap;
    assign req_addr   = AW'(32'(row_index) * 32'(MAX_COLS) + 32'(col_index));

    // ------------------------------------------------------------------
    // Write-back: saturating add of the product term to the old entry
    // ------------------------------------------------------------------
    always_comb
    begin
        sum        = acc_q_reg + term_q_reg;
        add_ovf    = (acc_q_reg[63] == term_q_reg[63]) && (sum[63] != acc_q_reg[63]);
        add_result = add_ovf ? (acc_q_reg[63] ? ACC_MIN : ACC_MAX) : sum;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        base_next       = base_reg;
        clr_addr_next   = clr_addr_reg;
        clr_reply_next  = clr_reply_reg;
        sat_flag_next   = sat_flag_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        sw_next         = sw_reg;
        sw_mag_next     = sw_mag_reg;
        sw_neg_next     = sw_neg_reg;
        p1_tag_next     = '0;
        p1_addr_next    = p1_addr_reg;
        shape_we        = 1'b0;
        shape_wa        = SW'(row_index);
        acc_clr_we      = 1'b0;

        // Make the saturation flag sticky over every written entry
        if (p8_res_reg.valid && (p8_res_reg.sat || add_ovf))
        begin
            sat_flag_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type)
                        REQ_LOAD_A:
                        begin
                            shape_we        = row_ok;
                            shape_wa        = SW'(row_index);
                            done_next       = 1'b1;
                            status_next     = !row_ok;
                            read_value_next = '0;
                        end
                        REQ_LOAD_B:
                        begin
                            shape_we        = col_ok;
                            shape_wa        = SW'(MAX_ROWS) + SW'(col_index);
                            done_next       = 1'b1;
                            status_next     = !col_ok;
                            read_value_next = '0;
                        end
                        REQ_UPDATE:
                        begin
                            sw_next    = scale_reg * value;
                            state_next = ST_PREP;
                        end
                        REQ_READ:
                        begin
                            if (row_ok && col_ok)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next       = 1'b1;
                                status_next     = 1'b1;
                                read_value_next = '0;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            sat_flag_next  = 1'b0;
                            clr_addr_next  = '0;
                            clr_reply_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        default:
                        begin
                            done_next       = 1'b1;
                            status_next     = 1'b1;
                            read_value_next = '0;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                done_next       = 1'b1;
                status_next     = 1'b0;
                read_value_next = acc_q_reg;
                state_next      = ST_IDLE;
            end

            ST_PREP:
            begin
                // Split scale*weight into sign and magnitude for the pipeline
                sw_mag_next = sw_reg[ACC_W-1] ? ACC_W'(-sw_reg) : ACC_W'(sw_reg);
                sw_neg_next = sw_reg[ACC_W-1];
                i_next      = '0;
                j_next      = '0;
                base_next   = '0;
                if ((eff_rows == '0) || (eff_cols == '0))
                begin
                    done_next       = 1'b1;
                    status_next     = 1'b0;
                    read_value_next = '0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ISSUE;
                end
            end

            ST_ISSUE:
            begin
                p1_tag_next.valid = 1'b1;
                p1_tag_next.last  = last_entry;
                p1_addr_next      = base_reg + AW'(j_reg);
                if (col_wrap)
                begin
                    j_next    = '0;
                    i_next    = i_reg + 6'd1;
                    base_next = base_reg + AW'(MAX_COLS);
                end
                else
                begin
                    j_next = j_reg + 6'd1;
                end
                if (last_entry)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                // Hold until the last entry has been written back
                if (p8_res_reg.valid && p8_res_reg.last)
                begin
                    done_next       = 1'b1;
                    status_next     = 1'b0;
                    read_value_next = '0;
                    state_next      = ST_IDLE;
                end
            end

            ST_CLEAR:
            begin
                acc_clr_we    = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next     = ST_IDLE;
                    clr_reply_next = 1'b0;
                    if (clr_reply_reg)
                    begin
                        done_next       = 1'b1;
                        status_next     = 1'b0;
                        read_value_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            i_reg         <= '0;
            j_reg         <= '0;
            base_reg      <= '0;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
            sat_flag_reg  <= 1'b0;
            done_reg      <= 1'b0;
            p1_tag_reg    <= '0;
            p8_res_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            base_reg      <= base_next;
            clr_addr_reg  <= clr_addr_next;
            clr_reply_reg <= clr_reply_next;
            sat_flag_reg  <= sat_flag_next;
            done_reg      <= done_next;
            p1_tag_reg    <= p1_tag_next;
            p8_res_reg    <= mac_res;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
        sw_reg         <= sw_next;
        sw_mag_reg     <= sw_mag_next;
        sw_neg_reg     <= sw_neg_next;
        p1_addr_reg    <= p1_addr_next;
        p8_addr_reg    <= mac_addr;
        term_q_reg     <= mac_term;
    end

    // ------------------------------------------------------------------
    // Shape-value memory: one write port, two registered read ports
    // ------------------------------------------------------------------
    assign shape_ra_row = SW'(i_reg);
    assign shape_ra_col = SW'(MAX_ROWS) + SW'(j_reg);

    always_ff @(posedge clk)
    begin
        if (shape_we)
        begin
            shape_mem[shape_wa] <= value;
        end
        row_q_reg <= shape_mem[shape_ra_row];
        col_q_reg <= shape_mem[shape_ra_col];
    end

    // ------------------------------------------------------------------
    // Accumulator memory: read the entry as its term leaves the pipeline,
    // write it back in the cycle after. Entries of one update never repeat,
    // so no forwarding is needed.
    // ------------------------------------------------------------------
    assign acc_we = acc_clr_we || p8_res_reg.valid;
    assign acc_wa = acc_clr_we ? clr_addr_reg : p8_addr_reg;
    assign acc_wd = acc_clr_we ? '0 : add_result;
    assign acc_ra = (state_reg == ST_IDLE) ? req_addr : mac_addr;

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_wa] <= acc_wd;
        end
        acc_q_reg <= acc_mem[acc_ra];
    end

    // ------------------------------------------------------------------
    // Product pipeline
    // ------------------------------------------------------------------
    wcma_mac #(
        .AW (AW)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (p1_tag_reg),
        .in_addr  (p1_addr_reg),
        .row_val  (row_q_reg),
        .col_val  (col_q_reg),
        .sw_mag   (sw_mag_reg),
        .sw_neg   (sw_neg_reg),
        .out_res  (mac_res),
        .out_addr (mac_addr),
        .term     (mac_term)
    );

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign saturated  = sat_flag_reg;

endmodule

`default_nettype wire
